/* rtl/hsl2rgb_pkg.sv */
// Shared types, constants and table builders for the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned HueRange    = 360;
  localparam int unsigned ByteMax     = 255;

  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [7:0] saturation;
    logic [7:0] lightness;
    logic [7:0] alpha_in;
  } hsl_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_pixel_t;

  // Data that bypasses the ramp math.
  typedef struct packed {
    logic       sat_zero;
    logic [7:0] lightness;
    logic [7:0] alpha;
  } side_t;

  typedef logic [31:0] tbl256_t [256];
  typedef logic [31:0] tbl8_t   [8];
  typedef logic [31:0] tbl64_t  [64];

  // round(i * 2^fb / 255), half up
  function automatic tbl256_t byte_frac_tbl(input int unsigned fb);
    tbl256_t          t;
    longint unsigned  num;
    for (int i = 0; i < 256; i++) begin
      num  = (longint'(i) << fb) + longint'(ByteMax / 2);
      t[i] = 32'(num / ByteMax);
    end
    return t;
  endfunction

  // Upper hue bits: (i * 64 * 2^fb) / 360, quotient or remainder
  function automatic tbl8_t hue_hi_tbl(input int unsigned fb, input bit want_rem);
    tbl8_t            t;
    longint unsigned  num;
    for (int i = 0; i < 8; i++) begin
      num  = (longint'(i) * 64) << fb;
      t[i] = want_rem ? 32'(num % HueRange) : 32'(num / HueRange);
    end
    return t;
  endfunction

  // Lower hue bits with rounding term: (i * 2^fb + 180) / 360
  function automatic tbl64_t hue_lo_tbl(input int unsigned fb, input bit want_rem);
    tbl64_t           t;
    longint unsigned  num;
    for (int i = 0; i < 64; i++) begin
      num  = (longint'(i) << fb) + longint'(HueRange / 2);
      t[i] = want_rem ? 32'(num % HueRange) : 32'(num / HueRange);
    end
    return t;
  endfunction

endpackage

/* rtl/hsl2rgb_frac.sv */
// Stage 1: hue wrap and conversion of hue, saturation, lightness to fractions.
module hsl2rgb_frac #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  hsl2rgb_pkg::hsl_pixel_t   pixel_i,
  output logic [FRAC_BITS:0]        s_o,
  output logic [FRAC_BITS:0]        l_o,
  output logic [FRAC_BITS-1:0]      h_o,
  output hsl2rgb_pkg::side_t        side_o
);
  import hsl2rgb_pkg::*;

  localparam tbl256_t ByteTbl = byte_frac_tbl(FRAC_BITS);
  localparam tbl8_t   HiQ     = hue_hi_tbl(FRAC_BITS, 1'b0);
  localparam tbl8_t   HiR     = hue_hi_tbl(FRAC_BITS, 1'b1);
  localparam tbl64_t  LoQ     = hue_lo_tbl(FRAC_BITS, 1'b0);
  localparam tbl64_t  LoR     = hue_lo_tbl(FRAC_BITS, 1'b1);

  logic [8:0]           hdeg;
  logic [2:0]           hi;
  logic [5:0]           lo;
  logic [9:0]           rsum;
  logic                 carry;
  logic [FRAC_BITS:0]   hsum;
  logic [FRAC_BITS:0]   s_q, l_q;
  logic [FRAC_BITS-1:0] h_q;
  side_t                side_d, side_q;

  always_comb begin
    hdeg  = (pixel_i.hue_degrees >= 9'(HueRange)) ?
            pixel_i.hue_degrees - 9'(HueRange) : pixel_i.hue_degrees;
    hi    = hdeg[8:6];
    lo    = hdeg[5:0];
    rsum  = {1'b0, HiR[hi][8:0]} + {1'b0, LoR[lo][8:0]};
    carry = (rsum >= 10'(HueRange));
    hsum  = HiQ[hi][FRAC_BITS:0] + LoQ[lo][FRAC_BITS:0] + {{FRAC_BITS{1'b0}}, carry};
    side_d.sat_zero  = (pixel_i.saturation == 8'd0);
    side_d.lightness = pixel_i.lightness;
    side_d.alpha     = pixel_i.alpha_in;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= ByteTbl[pixel_i.saturation][FRAC_BITS:0];
      l_q    <= ByteTbl[pixel_i.lightness][FRAC_BITS:0];
      h_q    <= hsum[FRAC_BITS-1:0];
      side_q <= side_d;
    end
  end

  assign s_o    = s_q;
  assign l_o    = l_q;
  assign h_o    = h_q;
  assign side_o = side_q;

endmodule

/* rtl/hsl2rgb_level.sv */
// Stages 2-3: v1/v2 levels and the three wrapped ramp arguments.
module hsl2rgb_level #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [FRAC_BITS:0]    s_i,
  input  logic [FRAC_BITS:0]    l_i,
  input  logic [FRAC_BITS-1:0]  h_i,
  input  hsl2rgb_pkg::side_t    side_i,
  output logic [FRAC_BITS:0]    v1_o,
  output logic [FRAC_BITS:0]    v2_o,
  output logic [FRAC_BITS:0]    d_o,
  output logic [FRAC_BITS-1:0]  xr_o,
  output logic [FRAC_BITS-1:0]  xg_o,
  output logic [FRAC_BITS-1:0]  xb_o,
  output hsl2rgb_pkg::side_t    side_o
);
  import hsl2rgb_pkg::*;

  localparam longint unsigned  OneL  = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS:0] One   = (FRAC_BITS+1)'(OneL);
  localparam logic [FRAC_BITS:0] Third = (FRAC_BITS+1)'((OneL + 1) / 3);
  localparam int unsigned      PW    = 2 * FRAC_BITS + 2;

  // stage 2
  logic [PW-1:0]        prod;
  logic [FRAC_BITS:0]   xr_sum, xb_sum;
  logic [FRAC_BITS-1:0] xr_d, xb_d;
  logic [FRAC_BITS:0]   p_q, s2_q, l2_q;
  logic [FRAC_BITS-1:0] xr2_q, xg2_q, xb2_q;
  side_t                side2_q;

  always_comb begin
    prod   = PW'(l_i) * PW'(s_i);
    xr_sum = {1'b0, h_i} + Third;
    xb_sum = {1'b0, h_i} + (One - Third);
    xr_d   = (xr_sum >= One) ? FRAC_BITS'(xr_sum - One) : FRAC_BITS'(xr_sum);
    xb_d   = (xb_sum >= One) ? FRAC_BITS'(xb_sum - One) : FRAC_BITS'(xb_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= prod[2*FRAC_BITS:FRAC_BITS];
      s2_q    <= s_i;
      l2_q    <= l_i;
      xr2_q   <= xr_d;
      xg2_q   <= h_i;
      xb2_q   <= xb_d;
      side2_q <= side_i;
    end
  end

  // stage 3
  logic [FRAC_BITS+1:0] v2w, twol, v1w, v1c, dw;
  logic [FRAC_BITS:0]   v1_q, v2_q, d_q;
  logic [FRAC_BITS-1:0] xr3_q, xg3_q, xb3_q;
  side_t                side3_q;

  always_comb begin
    if (!side2_q.lightness[7]) begin
      v2w = {1'b0, l2_q} + {1'b0, p_q};
    end else begin
      v2w = {1'b0, l2_q} + {1'b0, s2_q} - {1'b0, p_q};
    end
    twol = {l2_q, 1'b0};
    v1w  = (twol > v2w) ? twol - v2w : '0;
    v1c  = (v1w > v2w) ? v2w : v1w;
    dw   = v2w - v1c;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q    <= v1c[FRAC_BITS:0];
      v2_q    <= v2w[FRAC_BITS:0];
      d_q     <= dw[FRAC_BITS:0];
      xr3_q   <= xr2_q;
      xg3_q   <= xg2_q;
      xb3_q   <= xb2_q;
      side3_q <= side2_q;
    end
  end

  assign v1_o   = v1_q;
  assign v2_o   = v2_q;
  assign d_o    = d_q;
  assign xr_o   = xr3_q;
  assign xg_o   = xg3_q;
  assign xb_o   = xb3_q;
  assign side_o = side3_q;

endmodule

/* rtl/hsl2rgb_ramp.sv */
// Stages 4-6 of one channel: ramp segment, slope multiply, level select, byte scale.
module hsl2rgb_ramp #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [FRAC_BITS-1:0]  x_i,
  input  logic [FRAC_BITS:0]    v1_i,
  input  logic [FRAC_BITS:0]    v2_i,
  input  logic [FRAC_BITS:0]    d_i,
  output logic [7:0]            byte_o
);
  import hsl2rgb_pkg::*;

  typedef enum logic [1:0] {SegRise, SegHold, SegFall, SegLow} seg_e;

  localparam int unsigned XW = FRAC_BITS + 3;
  localparam int unsigned PW = 2 * FRAC_BITS + 2;
  localparam logic [XW-1:0] One  = XW'(64'd1 << FRAC_BITS);
  localparam logic [XW-1:0] One3 = XW'(64'd3 << FRAC_BITS);
  localparam logic [XW-1:0] One4 = XW'(64'd4 << FRAC_BITS);

  // stage 4
  logic [XW-1:0]      x6, tw;
  seg_e               seg_d, seg4_q;
  logic [FRAC_BITS:0] t_q, v1_4q, v2_4q, d_4q;

  always_comb begin
    x6 = XW'(x_i) * XW'(6);
    if (x6 < One) begin
      seg_d = SegRise;
      tw    = x6;
    end else if (x6 < One3) begin
      seg_d = SegHold;
      tw    = '0;
    end else if (x6 < One4) begin
      seg_d = SegFall;
      tw    = One4 - x6;
    end else begin
      seg_d = SegLow;
      tw    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg4_q <= seg_d;
      t_q    <= tw[FRAC_BITS:0];
      v1_4q  <= v1_i;
      v2_4q  <= v2_i;
      d_4q   <= d_i;
    end
  end

  // stage 5
  logic [PW-1:0]      prod;
  seg_e               seg5_q;
  logic [FRAC_BITS:0] p_q, v1_5q, v2_5q;

  assign prod = PW'(d_4q) * PW'(t_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg5_q <= seg4_q;
      p_q    <= prod[2*FRAC_BITS:FRAC_BITS];
      v1_5q  <= v1_4q;
      v2_5q  <= v2_4q;
    end
  end

  // stage 6
  logic [FRAC_BITS:0] ramp_d, ramp_q;

  always_comb begin
    case (seg5_q)
      SegRise, SegFall: ramp_d = v1_5q + p_q;
      SegHold:          ramp_d = v2_5q;
      SegLow:           ramp_d = v1_5q;
      default:          ramp_d = v1_5q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ramp_q <= ramp_d;
    end
  end

  // 255 * ramp / 2^F, held at 255
  logic [FRAC_BITS+8:0] scaled;
  logic [8:0]           b9;

  always_comb begin
    scaled = {ramp_q, 8'd0} - {8'd0, ramp_q};
    b9     = scaled[FRAC_BITS+8:FRAC_BITS];
    byte_o = (b9 > 9'(ByteMax)) ? 8'(ByteMax) : b9[7:0];
  end

endmodule

/* rtl/hsl_to_rgb_converter.sv */
// Top level of the pipelined HSL to RGB pixel converter.
//
//  channel   valid        ready        payload
//  input     in_valid_i   in_ready_o   in_pixel_i  (hue_degrees, saturation, lightness, alpha_in)
//  output    out_valid_o  out_ready_i  out_pixel_o (red, green, blue, alpha_out)
//
// Seven register stages; one transaction per cycle while the output is not stalled.
// Stage 1 table lookups, 2 l*s multiply, 3 v1/v2, 4 ramp segment,
// 5 slope multiply, 6 ramp level, 7 output register.
// Reset clears the stage valid bits only.
// A stall freezes every stage; in_ready_o is low only while the output is
// full and not taken.
module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  hsl2rgb_pkg::hsl_pixel_t  in_pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output hsl2rgb_pkg::rgb_pixel_t  out_pixel_o
);
  import hsl2rgb_pkg::*;

  localparam int unsigned NStages = 7;

  logic [NStages-1:0]   vld_q;
  logic                 en;

  logic [FRAC_BITS:0]   s1, l1;
  logic [FRAC_BITS-1:0] h1;
  side_t                side1, side3;
  logic [FRAC_BITS:0]   v1, v2, d;
  logic [FRAC_BITS-1:0] xr, xg, xb;
  logic [7:0]           r_byte, g_byte, b_byte;
  side_t                side4_q, side5_q, side6_q;
  rgb_pixel_t           out_d, out_q;

  assign en         = !vld_q[NStages-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  hsl2rgb_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
    .clk_i   (clk_i),
    .en_i    (en),
    .pixel_i (in_pixel_i),
    .s_o     (s1),
    .l_o     (l1),
    .h_o     (h1),
    .side_o  (side1)
  );

  hsl2rgb_level #(.FRAC_BITS(FRAC_BITS)) u_level (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s1),
    .l_i    (l1),
    .h_i    (h1),
    .side_i (side1),
    .v1_o   (v1),
    .v2_o   (v2),
    .d_o    (d),
    .xr_o   (xr),
    .xg_o   (xg),
    .xb_o   (xb),
    .side_o (side3)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_r (
    .clk_i(clk_i), .en_i(en), .x_i(xr), .v1_i(v1), .v2_i(v2), .d_i(d), .byte_o(r_byte)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_g (
    .clk_i(clk_i), .en_i(en), .x_i(xg), .v1_i(v1), .v2_i(v2), .d_i(d), .byte_o(g_byte)
  );

  hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_b (
    .clk_i(clk_i), .en_i(en), .x_i(xb), .v1_i(v1), .v2_i(v2), .d_i(d), .byte_o(b_byte)
  );

  // gray pixels bypass the ramps
  always_comb begin
    out_d.red       = side6_q.sat_zero ? side6_q.lightness : r_byte;
    out_d.green     = side6_q.sat_zero ? side6_q.lightness : g_byte;
    out_d.blue      = side6_q.sat_zero ? side6_q.lightness : b_byte;
    out_d.alpha_out = side6_q.alpha;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side3;
      side5_q <= side4_q;
      side6_q <= side5_q;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = vld_q[NStages-1];
  assign out_pixel_o = out_q;

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_out_from_stage6: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[NStages-2]))
    else $error("output valid rose without a transaction in stage 6");

  a_level_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> ((v1 <= v2) && (d == v2 - v1)))
    else $error("ramp levels out of order");

endmodule
